@@ rtl/core/recsf_pkg.sv @@
// Shared types, codes and constants for the end-around-carry ROM checksum block.
package recsf_pkg;

  // Image capacity in bytes; counts are one bit wider than the offsets
  localparam int unsigned MAX_IMAGE_BYTES = 65536;
  localparam int unsigned COUNT_W         = $clog2(MAX_IMAGE_BYTES + 1);
  localparam int unsigned ADDR_W          = 16;
  localparam int unsigned CFG_DATA_W      = 17;
  localparam int unsigned CFG_INDEX_W     = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_SUM   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_ENABLE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHECK_LENGTH   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FIX_ENABLE     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INJECT_ADDRESS = 3'd4;

  // Result status codes
  localparam logic [2:0] STATUS_OK           = 3'd0;
  localparam logic [2:0] STATUS_NO_EXPECTED  = 3'd1;
  localparam logic [2:0] STATUS_ADDR_BEYOND  = 3'd2;
  localparam logic [2:0] STATUS_ZERO_SUM_BAD = 3'd3;
  localparam logic [2:0] STATUS_TOO_LONG     = 3'd4;

  // Stream state after the current byte has been folded in
  typedef struct packed {
    logic [7:0]         running_sum;
    logic [COUNT_W-1:0] byte_count;
    logic               seen_nonzero;
    logic [7:0]         captured_byte;
    logic               too_long;
  } stream_t;

  // Configuration registers as seen by the result logic
  typedef struct packed {
    logic [7:0]            expected_sum;
    logic                  compare_enable;
    logic [COUNT_W-1:0]    check_length;
    logic                  fix_enable;
    logic [ADDR_W-1:0]     inject_address;
  } config_t;

  // One result item
  typedef struct packed {
    logic [7:0]         checksum;
    logic [COUNT_W-1:0] bytes_summed;
    logic [COUNT_W-1:0] total_bytes;
    logic               sum_matches;
    logic [7:0]         fix_byte;
    logic [2:0]         status;
  } result_t;

endpackage

@@ rtl/core/recsf_verdict.sv @@
// Final-byte evaluation: summed count, compare, correcting byte and status.
module recsf_verdict (
  input  recsf_pkg::stream_t stream,
  input  recsf_pkg::config_t cfg,
  output recsf_pkg::result_t result
);

  logic [recsf_pkg::COUNT_W-1:0] summed;
  logic signed [9:0]             t_raw;
  logic signed [9:0]             t_adj;
  logic [2:0]                    status;
  logic                          fix_valid;

  // Limit the summed count to check_length when that is set
  always_comb begin
    summed = stream.byte_count;
    if (cfg.check_length != '0 && cfg.check_length < stream.byte_count) begin
      summed = cfg.check_length;
    end
  end

  // Correcting byte: shift the captured byte by the sum error, fold the wrap
  always_comb begin
    t_raw = $signed({2'b00, stream.captured_byte}) + $signed({2'b00, cfg.expected_sum})
          - $signed({2'b00, stream.running_sum});
    if (t_raw < 10'sd0) begin
      t_adj = t_raw - 10'sd1;
    end else if (t_raw > 10'sd255) begin
      t_adj = t_raw + 10'sd1;
    end else begin
      t_adj = t_raw;
    end
  end

  // Pick status by priority; fix only when every check passes
  always_comb begin
    status    = recsf_pkg::STATUS_OK;
    fix_valid = 1'b0;
    if (stream.too_long) begin
      status = recsf_pkg::STATUS_TOO_LONG;
    end else if (cfg.fix_enable) begin
      if (!cfg.compare_enable) begin
        status = recsf_pkg::STATUS_NO_EXPECTED;
      end else if ({1'b0, cfg.inject_address} >= stream.byte_count) begin
        status = recsf_pkg::STATUS_ADDR_BEYOND;
      end else if (cfg.expected_sum == 8'd0 && stream.seen_nonzero) begin
        status = recsf_pkg::STATUS_ZERO_SUM_BAD;
      end else begin
        fix_valid = 1'b1;
      end
    end
  end

  always_comb begin
    result.checksum     = stream.running_sum;
    result.bytes_summed = summed;
    result.total_bytes  = stream.byte_count;
    result.sum_matches  = cfg.compare_enable && (stream.running_sum == cfg.expected_sum);
    result.fix_byte     = fix_valid ? t_adj[7:0] : 8'd0;
    result.status       = status;
  end

endmodule

@@ rtl/core/rom_end_around_carry_checksum_fix.sv @@
// Top level: end-around-carry ROM checksum with correcting byte and skid output.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid / in_stall       data_byte, last_byte
//   out      output     out_valid / out_stall     checksum, bytes_summed, total_bytes,
//                                                 sum_matches, fix_byte, status
//   cfg      input      cfg_write                 cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; the sum, count and capture
// update in the cycle of the transfer, and a last byte loads its result into the
// output register at that same edge, or into the skid slot when that is held.
// Reset (rst, synchronous) clears the stream state, the registers and both
// output slots. A held result does not block input: a second result parks in
// the skid slot, and in_stall rises only while that slot is occupied.
module rom_end_around_carry_checksum_fix (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          data_byte,
  input  logic                                last_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          checksum,
  output logic [recsf_pkg::COUNT_W-1:0]       bytes_summed,
  output logic [recsf_pkg::COUNT_W-1:0]       total_bytes,
  output logic                                sum_matches,
  output logic [7:0]                          fix_byte,
  output logic [2:0]                          status,
  input  logic                                cfg_write,
  input  logic [recsf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [recsf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  recsf_pkg::config_t cfg;
  recsf_pkg::stream_t stream;
  recsf_pkg::stream_t stream_next;
  recsf_pkg::result_t result_next;
  recsf_pkg::result_t out_reg;
  recsf_pkg::result_t skid_reg;
  logic               skid_valid;
  logic               in_xfer;
  logic               out_xfer;
  logic               new_result;
  logic [8:0]         sum_wide;

  assign in_stall   = skid_valid;
  assign in_xfer    = in_valid && !skid_valid;
  assign out_xfer   = out_valid && !out_stall;
  assign new_result = in_xfer && last_byte;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        recsf_pkg::REG_EXPECTED_SUM:   cfg.expected_sum   <= cfg_data[7:0];
        recsf_pkg::REG_COMPARE_ENABLE: cfg.compare_enable <= cfg_data[0];
        recsf_pkg::REG_CHECK_LENGTH:   cfg.check_length   <= cfg_data[recsf_pkg::COUNT_W-1:0];
        recsf_pkg::REG_FIX_ENABLE:     cfg.fix_enable     <= cfg_data[0];
        recsf_pkg::REG_INJECT_ADDRESS: cfg.inject_address <= cfg_data[recsf_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Fold the incoming byte into the stream state
  assign sum_wide = {1'b0, stream.running_sum} + {1'b0, data_byte};

  always_comb begin
    stream_next = stream;
    if (stream.byte_count[recsf_pkg::COUNT_W-1]) begin
      // capacity reached: drop the byte
      stream_next.too_long = 1'b1;
    end else begin
      if (data_byte != 8'd0) begin
        stream_next.seen_nonzero = 1'b1;
      end
      if (stream.byte_count == {1'b0, cfg.inject_address}) begin
        stream_next.captured_byte = data_byte;
      end
      if (cfg.check_length == '0 || stream.byte_count < cfg.check_length) begin
        stream_next.running_sum = sum_wide[7:0] + {7'd0, sum_wide[8]};
      end
      stream_next.byte_count = stream.byte_count + 1'b1;
    end
  end

  recsf_verdict u_verdict (
    .stream (stream_next),
    .cfg    (cfg),
    .result (result_next)
  );

  // Advance stream state; clear it after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      stream <= '0;
    end else if (in_xfer) begin
      stream <= last_byte ? '0 : stream_next;
    end
  end

  // Output register with one skid slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_xfer) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= new_result;
        end
      end else if (new_result) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Load the result payload into whichever slot takes it
  always_ff @(posedge clk) begin
    if (!out_valid || out_xfer) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (new_result) begin
        out_reg <= result_next;
      end
    end else if (new_result) begin
      skid_reg <= result_next;
    end
  end

  assign checksum     = out_reg.checksum;
  assign bytes_summed = out_reg.bytes_summed;
  assign total_bytes  = out_reg.total_bytes;
  assign sum_matches  = out_reg.sum_matches;
  assign fix_byte     = out_reg.fix_byte;
  assign status       = out_reg.status;

endmodule

@@ tb/rom_end_around_carry_checksum_fix_tb.sv @@
// Self-checking testbench for the end-around-carry ROM checksum block.
module rom_end_around_carry_checksum_fix_tb;
  import recsf_pkg::*;

  typedef logic [7:0] image_t[$];

  // Predicts the result of each image and checks the block's results in order
  class image_checksum_sb;
    logic [7:0]         expected_sum;
    logic               compare_on;
    logic [COUNT_W-1:0] sum_limit;
    logic               fix_on;
    logic [ADDR_W-1:0]  patch_addr;
    logic [7:0]         run_sum;
    logic [COUNT_W-1:0] byte_count;
    logic               nonzero_seen;
    logic               overflowed;
    logic [7:0]         patch_orig;
    result_t            image_results[$];
    int                 mismatches;

    function new();
      expected_sum = '0;
      compare_on   = 1'b0;
      sum_limit    = '0;
      fix_on       = 1'b0;
      patch_addr   = '0;
      run_sum      = '0;
      byte_count   = '0;
      nonzero_seen = 1'b0;
      overflowed   = 1'b0;
      patch_orig   = '0;
      mismatches   = 0;
    endfunction

    function int pending();
      return image_results.size();
    endfunction

    task report(input string msg);
      if (mismatches < 50) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // Mirror a register write; unused indexes are dropped
    function void write_reg(input logic [CFG_INDEX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_EXPECTED_SUM:   expected_sum = data[7:0];
        REG_COMPARE_ENABLE: compare_on   = data[0];
        REG_CHECK_LENGTH:   sum_limit    = data[COUNT_W-1:0];
        REG_FIX_ENABLE:     fix_on       = data[0];
        REG_INJECT_ADDRESS: patch_addr   = data[ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    // Fold one accepted byte into the image state; queue a result on the last byte
    function void take_byte(input logic [7:0] b, input logic last);
      int      acc;
      int      t;
      result_t r;
      if (byte_count >= MAX_IMAGE_BYTES) begin
        overflowed = 1'b1;
      end else begin
        if (b != 8'h00) nonzero_seen = 1'b1;
        if (byte_count == patch_addr) patch_orig = b;
        if (sum_limit == 0 || byte_count < sum_limit) begin
          acc = run_sum + b;
          if (acc > 255) acc = acc - 255;
          run_sum = acc[7:0];
        end
        byte_count++;
      end
      if (!last) return;

      r.checksum     = run_sum;
      r.bytes_summed = (sum_limit != 0 && sum_limit < byte_count) ? sum_limit : byte_count;
      r.total_bytes  = byte_count;
      r.sum_matches  = compare_on && (run_sum == expected_sum);
      r.fix_byte     = 8'h00;
      r.status       = STATUS_OK;
      if (overflowed) begin
        r.status = STATUS_TOO_LONG;
      end else if (fix_on) begin
        if (!compare_on) begin
          r.status = STATUS_NO_EXPECTED;
        end else if (patch_addr >= byte_count) begin
          r.status = STATUS_ADDR_BEYOND;
        end else if (expected_sum == 8'h00 && nonzero_seen) begin
          r.status = STATUS_ZERO_SUM_BAD;
        end else begin
          // Step over the one's-complement wrap when the new byte leaves 0..255
          t = int'(patch_orig) + int'(expected_sum) - int'(run_sum);
          if (t < 0) t = t - 1;
          else if (t > 255) t = t + 1;
          r.fix_byte = t[7:0];
        end
      end
      image_results.push_back(r);

      run_sum      = '0;
      byte_count   = '0;
      nonzero_seen = 1'b0;
      overflowed   = 1'b0;
      patch_orig   = '0;
    endfunction

    // Compare one result transfer with the oldest predicted result
    task check_result(input result_t got);
      result_t want;
      if (image_results.size() == 0) begin
        report($sformatf("result with no image pending, checksum %02h", got.checksum));
        return;
      end
      want = image_results.pop_front();
      if (got.checksum !== want.checksum)
        report($sformatf("checksum %02h, want %02h", got.checksum, want.checksum));
      if (got.bytes_summed !== want.bytes_summed)
        report($sformatf("bytes_summed %0d, want %0d", got.bytes_summed, want.bytes_summed));
      if (got.total_bytes !== want.total_bytes)
        report($sformatf("total_bytes %0d, want %0d", got.total_bytes, want.total_bytes));
      if (got.sum_matches !== want.sum_matches)
        report($sformatf("sum_matches %b, want %b", got.sum_matches, want.sum_matches));
      if (got.fix_byte !== want.fix_byte)
        report($sformatf("fix_byte %02h, want %02h", got.fix_byte, want.fix_byte));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             data_byte;
  logic                   last_byte;
  logic                   out_valid;
  logic                   out_stall;
  logic [7:0]             checksum;
  logic [COUNT_W-1:0]     bytes_summed;
  logic [COUNT_W-1:0]     total_bytes;
  logic                   sum_matches;
  logic [7:0]             fix_byte;
  logic [2:0]             status;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  image_checksum_sb sb;
  bit               gaps_on;

  rom_end_around_carry_checksum_fix dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .checksum     (checksum),
    .bytes_summed (bytes_summed),
    .total_bytes  (total_bytes),
    .sum_matches  (sum_matches),
    .fix_byte     (fix_byte),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned idle_span();
    int unsigned p;
    p = $urandom_range(99, 0);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Offer one byte, with an optional gap first; hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned span;
    span = gaps_on ? idle_span() : 0;
    if (span != 0) begin
      in_valid <= 1'b0;
      repeat (span) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_image(input image_t img);
    for (int i = 0; i < img.size(); i++) send_byte(img[i], i == img.size() - 1);
  endtask

  // Drain, then write every register and one unused index
  task automatic program_regs(input logic [7:0] es, input logic ce,
                              input logic [COUNT_W-1:0] cl, input logic fe,
                              input logic [ADDR_W-1:0] ia);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_EXPECTED_SUM;
    cfg_data  <= {9'($urandom), es};
    @(posedge clk);
    cfg_index <= REG_COMPARE_ENABLE;
    cfg_data  <= {16'($urandom), ce};
    @(posedge clk);
    cfg_index <= REG_CHECK_LENGTH;
    cfg_data  <= cl;
    @(posedge clk);
    cfg_index <= REG_FIX_ENABLE;
    cfg_data  <= {16'($urandom), fe};
    @(posedge clk);
    cfg_index <= REG_INJECT_ADDRESS;
    cfg_data  <= {1'($urandom), ia};
    @(posedge clk);
    cfg_index <= CFG_INDEX_W'($urandom_range((1 << CFG_INDEX_W) - 1,
                                             REG_INJECT_ADDRESS + 1));
    cfg_data  <= 17'($urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Sample every transfer and register write at the clock edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.take_byte(data_byte, last_byte);
      if (out_valid && !out_stall)
        sb.check_result('{checksum, bytes_summed, total_bytes, sum_matches, fix_byte, status});
    end
  end

  // Stall the result side in bursts, with quiet stretches between
  initial begin
    int unsigned span;
    int unsigned quiet;
    forever begin
      span = idle_span();
      if (span != 0) begin
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
      end
      out_stall <= 1'b0;
      quiet = ($urandom_range(4, 0) == 0) ? $urandom_range(300, 50) : $urandom_range(6, 1);
      repeat (quiet) @(posedge clk);
    end
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    image_t             img;
    int unsigned        sent;
    int unsigned        p;
    int unsigned        len;
    int unsigned        kind;
    int unsigned        phase_images;
    logic [7:0]         es;
    logic               ce;
    logic               fe;
    logic [COUNT_W-1:0] cl;
    logic [ADDR_W-1:0]  ia;
    int                 w;

    sb = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    data_byte <= 8'h00;
    last_byte <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= REG_EXPECTED_SUM;
    cfg_data  <= '0;
    gaps_on    = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: plain sums, single-byte extremes
    send_image('{8'hFF});
    send_image('{8'h00, 8'h01});

    // Fix computed, address inside the image
    program_regs(8'hA5, 1'b1, '0, 1'b1, 16'd1);
    send_image('{8'h80, 8'hFF, 8'h7F, 8'h01});

    // Zero expected sum: all-zero image fixes, any nonzero byte cannot
    program_regs(8'h00, 1'b1, '0, 1'b1, 16'd0);
    send_image('{8'h00, 8'h00, 8'h00});
    send_image('{8'h00, 8'h05});

    // Fix without an expected sum
    program_regs(8'h10, 1'b0, '0, 1'b1, 16'd0);
    send_image('{8'h20});

    // Address beyond the image, length limit shorter than the image
    program_regs(8'h10, 1'b1, 17'd2, 1'b1, 16'd5);
    send_image('{8'hF0, 8'hF0, 8'h33});

    // Address outside the summed part still gets a fix
    program_regs(8'hFF, 1'b1, 17'd1, 1'b1, 16'd2);
    send_image('{8'h01, 8'h02, 8'h03});

    // Compare only, matching sum
    program_regs(8'h46, 1'b1, '0, 1'b0, 16'd0);
    send_image('{8'h12, 8'h34});

    // Fix wraps below zero, then above 255
    program_regs(8'h10, 1'b1, '0, 1'b1, 16'd0);
    send_image('{8'h00, 8'h80});
    program_regs(8'h30, 1'b1, '0, 1'b1, 16'd0);
    send_image('{8'hF0, 8'h20});

    // Random phases: new settings, then a few images each
    sent = 0;
    while (sent < 1200) begin
      p  = $urandom_range(99, 0);
      es = (p < 10) ? 8'h00 : (p < 20) ? 8'hFF : 8'($urandom);
      ce = $urandom_range(9, 0) < 8;
      p  = $urandom_range(99, 0);
      if (p < 45) cl = '0;
      else if (p < 85) cl = COUNT_W'($urandom_range(30, 1));
      else if (p < 93) cl = COUNT_W'(MAX_IMAGE_BYTES);
      else cl = COUNT_W'($urandom_range(MAX_IMAGE_BYTES, 1));
      fe = $urandom_range(3, 0) != 0;
      p  = $urandom_range(99, 0);
      if (p < 60) ia = ADDR_W'($urandom_range(10, 0));
      else if (p < 85) ia = ADDR_W'($urandom_range(40, 0));
      else if (p < 92) ia = 16'hFFFF;
      else ia = 16'($urandom);
      program_regs(es, ce, cl, fe, ia);

      gaps_on      = $urandom_range(3, 0) != 0;
      phase_images = $urandom_range(6, 1);
      repeat (phase_images) begin
        p = $urandom_range(99, 0);
        if (p < 75) len = $urandom_range(16, 1);
        else if (p < 97) len = $urandom_range(100, 17);
        else len = $urandom_range(400, 101);
        kind = $urandom_range(9, 0);
        img.delete();
        repeat (len) begin
          if (kind == 0) begin
            img.push_back(8'h00);
          end else if (kind == 1) begin
            case ($urandom_range(4, 0))
              0: img.push_back(8'h00);
              1: img.push_back(8'hFF);
              2: img.push_back(8'h80);
              3: img.push_back(8'h7F);
              default: img.push_back(8'h01);
            endcase
          end else begin
            img.push_back(8'($urandom));
          end
        end
        send_image(img);
        sent += len;
      end
    end

    // Drain the last results and watch for stray ones
    in_valid <= 1'b0;
    @(posedge clk);
    for (w = 0; w < 5000 && sb.pending() != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ rom_end_around_carry_checksum_fix.f @@
rtl/core/recsf_pkg.sv
rtl/core/recsf_verdict.sv
rtl/core/rom_end_around_carry_checksum_fix.sv
tb/rom_end_around_carry_checksum_fix_tb.sv
